### rtl/c2p_pkg.sv
package c2p_pkg;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 2;
	localparam int ADDR_W = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CONVERT_RGB565 = 2'd3;

	localparam logic [10:0] LINE_WIDTH_RESET = 11'd320;
	localparam logic [10:0] LINE_COUNT_RESET = 11'd240;
	localparam logic [3:0] PLANE_COUNT_RESET = 4'd4;
	localparam logic CONVERT_RESET = 1'b1;

	// effective settings after clamping
	typedef struct packed {
		logic [7:0]  bytes_per_row;
		logic [10:0] rows;
		logic [2:0]  last_plane;
		logic        rgb565;
	} cfg_t;

	// one completed group of eight pixels, all planes
	typedef struct packed {
		logic [7:0][7:0]    bytes;
		logic [ADDR_W-1:0]  base_address;
		logic [7:0]         bytes_per_row;
		logic [2:0]         last_plane;
		logic               frame_end;
	} group_t;

	function automatic logic [7:0] chunky_index(input logic [15:0] px, input logic rgb565);
		logic [7:0] idx;
		if (rgb565) begin
			idx = {4'b0000, px[15:14], px[10:9]};
		end else begin
			idx = px[7:0];
		end
		return idx;
	endfunction

endpackage

### rtl/c2p_cfg.sv
module c2p_cfg #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_PLANES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [c2p_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [c2p_pkg::CFG_DATA_W-1:0]  cfg_data,
	output c2p_pkg::cfg_t                 cfg
);
	import c2p_pkg::*;

	localparam logic [9:0] BPR_MAX = 10'(MAX_WIDTH / 8);
	localparam logic [12:0] ROWS_MAX = 13'(MAX_HEIGHT);
	localparam logic [3:0] PLANES_MAX = 4'(MAX_PLANES);

	logic [10:0] line_width_q;
	logic [10:0] line_count_q;
	logic [3:0]  plane_count_q;
	logic        convert_q;
	logic [7:0]  bpr;
	logic [10:0] rows;
	logic [3:0]  planes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
			line_count_q <= LINE_COUNT_RESET;
			plane_count_q <= PLANE_COUNT_RESET;
			convert_q <= CONVERT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[10:0];
				REG_LINE_COUNT: line_count_q <= cfg_data[10:0];
				REG_PLANE_COUNT: plane_count_q <= cfg_data[3:0];
				REG_CONVERT_RGB565: convert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bpr = line_width_q[10:3];
		if (bpr == 8'd0) begin
			bpr = 8'd1;
		end else if ({2'b00, bpr} > BPR_MAX) begin
			bpr = BPR_MAX[7:0];
		end

		rows = line_count_q;
		if (rows == 11'd0) begin
			rows = 11'd1;
		end else if ({2'b00, rows} > ROWS_MAX) begin
			rows = ROWS_MAX[10:0];
		end

		planes = plane_count_q;
		if (planes == 4'd0) begin
			planes = 4'd1;
		end else if (planes > PLANES_MAX) begin
			planes = PLANES_MAX;
		end

		cfg.bytes_per_row = bpr;
		cfg.rows = rows;
		cfg.last_plane = 3'(planes - 4'd1);
		cfg.rgb565 = convert_q;
	end

endmodule

### rtl/c2p_gather.sv
module c2p_gather #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_PLANES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  c2p_pkg::cfg_t       cfg,
	input  logic [15:0]         pixel,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	output logic                grp_valid,
	output c2p_pkg::group_t     grp,
	input  logic                grp_done
);
	import c2p_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 2048) ? 11 :
		((MAX_WIDTH < 16) ? 4 : $clog2(MAX_WIDTH));
	localparam int ROW_W = (MAX_HEIGHT > 2048) ? 11 :
		((MAX_HEIGHT < 2) ? 1 : $clog2(MAX_HEIGHT));

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [7:0]        acc_q [MAX_PLANES];
	logic [7:0]        acc_next [MAX_PLANES];
	logic              grp_valid_q;
	group_t            grp_q;

	logic [7:0]        idx;
	logic [2:0]        pos;
	logic              row_end;
	logic              frame_end;
	logic              group_end;
	logic              accept;
	logic [3:0]        planes;
	logic [11:0]       row_step;
	logic [7:0][7:0]   grp_bytes;

	assign idx = chunky_index(pixel, cfg.rgb565);
	assign pos = 3'd7 - col_q[2:0];
	assign row_end = (12'(col_q) + 12'd1) >= {1'b0, cfg.bytes_per_row, 3'b000};
	assign frame_end = row_end && ((12'(row_q) + 12'd1) >= {1'b0, cfg.rows});
	assign group_end = (col_q[2:0] == 3'd7) || row_end;
	assign planes = {1'b0, cfg.last_plane} + 4'd1;
	assign row_step = 12'(cfg.bytes_per_row) * 12'(planes);

	// a group-ending pixel needs the snapshot slot
	assign pixel_stall = grp_valid_q && group_end && !grp_done;
	assign accept = pixel_valid && !pixel_stall;

	always_comb begin
		for (int p = 0; p < MAX_PLANES; p++) begin
			acc_next[p] = acc_q[p];
			acc_next[p][pos] = idx[p];
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_bytes
		if (g < MAX_PLANES) begin : g_used
			assign grp_bytes[g] = acc_next[g];
		end else begin : g_unused
			assign grp_bytes[g] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			row_base_q <= '0;
			for (int p = 0; p < MAX_PLANES; p++) begin
				acc_q[p] <= 8'd0;
			end
		end else if (accept) begin
			for (int p = 0; p < MAX_PLANES; p++) begin
				acc_q[p] <= acc_next[p];
			end
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
					row_base_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					row_base_q <= row_base_q + ADDR_W'(row_step);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
		end else if (accept && group_end) begin
			grp_valid_q <= 1'b1;
		end else if (grp_done) begin
			grp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && group_end) begin
			grp_q.bytes <= grp_bytes;
			grp_q.base_address <= row_base_q + ADDR_W'(col_q[COL_W-1:3]);
			grp_q.bytes_per_row <= cfg.bytes_per_row;
			grp_q.last_plane <= cfg.last_plane;
			grp_q.frame_end <= frame_end;
		end
	end

	assign grp_valid = grp_valid_q;
	assign grp = grp_q;

endmodule

### rtl/c2p_emit.sv
module c2p_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        grp_valid,
	input  c2p_pkg::group_t             grp,
	output logic                        grp_done,
	output logic                        plane_valid,
	input  logic                        plane_stall,
	output logic [7:0]                  plane_byte,
	output logic [c2p_pkg::ADDR_W-1:0]  byte_address,
	output logic [2:0]                  plane_number,
	output logic                        last_of_group,
	output logic                        frame_done
);
	import c2p_pkg::*;

	logic [2:0]        plane_q;
	logic [ADDR_W-1:0] addr_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic [ADDR_W-1:0] address_q;
	logic [2:0]        number_q;
	logic              last_q;
	logic              frame_q;

	logic              load;
	logic              take;
	logic              last;
	logic [ADDR_W-1:0] addr_cur;

	assign load = !valid_q || !plane_stall;
	assign take = load && grp_valid;
	assign last = (plane_q == grp.last_plane);
	assign addr_cur = (plane_q == 3'd0) ? grp.base_address : addr_q;
	assign grp_done = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= grp_valid;
			end
			if (take) begin
				plane_q <= last ? 3'd0 : plane_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q <= addr_cur + ADDR_W'(grp.bytes_per_row);
			byte_q <= grp.bytes[plane_q];
			address_q <= addr_cur;
			number_q <= plane_q;
			last_q <= last;
			frame_q <= grp.frame_end;
		end
	end

	assign plane_valid = valid_q;
	assign plane_byte = byte_q;
	assign byte_address = address_q;
	assign plane_number = number_q;
	assign last_of_group = last_q;
	assign frame_done = frame_q;

endmodule

### rtl/chunky_to_planar_converter.sv
// Output path: a pixel that closes a group of eight is registered into the group snapshot, then
// its plane 0 byte into the output register; further plane bytes follow one per cycle unless plane_stall holds off.
// Throughput: one pixel per cycle while pixel_stall is low; a group of P planes drains from a one-group
// snapshot register, so the pixel stream stalls only if the output side holds off.
// Reset: counters, row base and accumulators clear; registers return to their defaults.
module chunky_to_planar_converter #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_PLANES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [c2p_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [c2p_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [15:0]                     pixel,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	output logic [7:0]                      plane_byte,
	output logic [c2p_pkg::ADDR_W-1:0]      byte_address,
	output logic [2:0]                      plane_number,
	output logic                            last_of_group,
	output logic                            frame_done,
	output logic                            plane_valid,
	input  logic                            plane_stall
);
	import c2p_pkg::*;

	cfg_t   cfg;
	group_t grp;
	logic   grp_valid;
	logic   grp_done;

	c2p_cfg #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_PLANES(MAX_PLANES)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	c2p_gather #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_PLANES(MAX_PLANES)
	) u_gather (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pixel(pixel),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.grp_valid(grp_valid),
		.grp(grp),
		.grp_done(grp_done)
	);

	c2p_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.grp_valid(grp_valid),
		.grp(grp),
		.grp_done(grp_done),
		.plane_valid(plane_valid),
		.plane_stall(plane_stall),
		.plane_byte(plane_byte),
		.byte_address(byte_address),
		.plane_number(plane_number),
		.last_of_group(last_of_group),
		.frame_done(frame_done)
	);

endmodule
